FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the rtl folder
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication under reset
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ps2mt_pkg.sv
// ----------------------------------------------------------------------------
// ps2mt_pkg
// shared constants for the ps/2 mouse packet and cursor tracker
// ----------------------------------------------------------------------------
package ps2mt_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned DELTA_W = 9;
  localparam int unsigned RES_W   = 13;
  localparam int unsigned CFG_IDX_W = 1;

  // header bit positions
  localparam int unsigned BTN_LEFT_BIT  = 0;
  localparam int unsigned BTN_RIGHT_BIT = 1;
  localparam int unsigned BTN_MID_BIT   = 2;
  localparam int unsigned SYNC_BIT      = 3;
  localparam int unsigned SIGN_X_BIT    = 4;
  localparam int unsigned SIGN_Y_BIT    = 5;
  localparam int unsigned OVF_X_BIT     = 6;
  localparam int unsigned OVF_Y_BIT     = 7;

  // byte position codes
  localparam logic [1:0] POS_HEADER = 2'd0;
  localparam logic [1:0] POS_X      = 2'd1;
  localparam logic [1:0] POS_Y      = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_X_RES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_RES = 1'b1;

  localparam logic [RES_W-1:0] X_RES_RESET = 13'd1024;
  localparam logic [RES_W-1:0] Y_RES_RESET = 13'd768;

  typedef logic signed [DELTA_W-1:0] delta_t;

endpackage

FILE: rtl/ps2mt_clamp.sv
// ----------------------------------------------------------------------------
// ps2mt_clamp
// adds or subtracts a 9-bit signed delta on a cursor position and clamps the
// result to 0 through resolution minus 1, capped at the position range
// ----------------------------------------------------------------------------
module ps2mt_clamp #(
  parameter int unsigned POSITION_BITS = 12
) (
  input  logic [POSITION_BITS-1:0]   pos_i,
  input  ps2mt_pkg::delta_t          delta_i,
  input  logic                       subtract_i,
  input  logic [ps2mt_pkg::RES_W-1:0] res_i,
  output logic [POSITION_BITS-1:0]   hi_o,
  output logic [POSITION_BITS-1:0]   pos_o
);
  import ps2mt_pkg::*;

  localparam int unsigned SW = POSITION_BITS + 2;
  localparam int unsigned CW = (POSITION_BITS > RES_W) ? POSITION_BITS : RES_W;
  localparam logic [CW-1:0] TOP = CW'((64'd1 << POSITION_BITS) - 64'd1);

  logic [RES_W-1:0]     lim;
  logic [CW-1:0]        lim_ext;
  logic [POSITION_BITS-1:0] hi;
  logic signed [SW-1:0] pos_s;
  logic signed [SW-1:0] delta_s;
  logic signed [SW-1:0] sum;
  logic signed [SW-1:0] hi_s;

  always_comb begin
    lim     = (res_i == '0) ? '0 : res_i - RES_W'(1);
    lim_ext = CW'(lim);
    hi      = (lim_ext > TOP) ? POSITION_BITS'(TOP) : POSITION_BITS'(lim_ext);
  end

  always_comb begin
    pos_s   = signed'({2'b00, pos_i});
    delta_s = SW'(delta_i);
    sum     = subtract_i ? (pos_s - delta_s) : (pos_s + delta_s);
    hi_s    = signed'({2'b00, hi});
    if (sum < 0) begin
      pos_o = '0;
    end else if (sum > hi_s) begin
      pos_o = hi;
    end else begin
      pos_o = sum[POSITION_BITS-1:0];
    end
  end

  assign hi_o = hi;

endmodule

FILE: rtl/ps2_mouse_packet_cursor_tracker_core.sv
// ----------------------------------------------------------------------------
// ps2_mouse_packet_cursor_tracker_core
// decodes three-byte ps/2 mouse packets and tracks a clamped screen cursor
//
//   channel | dir | signals                                  | taken when
//   in      | in  | in_valid_i, in_stall_o, data_byte_i      | valid & !stall
//   out     | out | out_valid_o, out_stall_i, packet fields  | valid & !stall
//   cfg     | in  | cfg_we_i, cfg_index_i, cfg_data_i        | we
//
// one byte per cycle while in_stall_o is low; a packet result appears in the
// output register the cycle after its third byte is taken
// reset clears the byte position, presets cursor (center) and resolutions
// in_stall_o rises only when the next byte would finish a packet while the
// output register still holds a result that is stalled
// ----------------------------------------------------------------------------
module ps2_mouse_packet_cursor_tracker_core #(
  parameter int unsigned POSITION_BITS = 12
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ps2mt_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ps2mt_pkg::RES_W-1:0]     cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [ps2mt_pkg::BYTE_W-1:0]    data_byte_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            left_button_o,
  output logic                            right_button_o,
  output logic                            middle_button_o,
  output logic                            x_overflow_flag_o,
  output logic                            y_overflow_flag_o,
  output ps2mt_pkg::delta_t               move_x_o,
  output ps2mt_pkg::delta_t               move_y_o,
  output logic [POSITION_BITS-1:0]        cursor_x_o,
  output logic [POSITION_BITS-1:0]        cursor_y_o
);
  import ps2mt_pkg::*;

  `include "assert_macros.svh"

  logic [RES_W-1:0]  x_res_q, y_res_q;
  logic [1:0]        pos_q, pos_d;
  logic [BYTE_W-1:0] header_q, header_d;
  logic [BYTE_W-1:0] x_byte_q, x_byte_d;
  logic [POSITION_BITS-1:0] ptr_x_q, ptr_y_q;
  logic [POSITION_BITS-1:0] new_x, new_y, x_hi, y_hi;
  logic              out_valid_q, out_valid_d;
  logic              in_accept, out_accept, load;
  delta_t            dx, dy;

  logic              left_q, right_q, mid_q, ovf_x_q, ovf_y_q;
  delta_t            move_x_q, move_y_q;

  assign out_accept = out_valid_q & ~out_stall_i;
  assign in_stall_o = (pos_q == POS_Y) & out_valid_q & out_stall_i;
  assign in_accept  = in_valid_i & ~in_stall_o;
  assign load       = in_accept & (pos_q == POS_Y);

  assign dx = {header_q[SIGN_X_BIT], x_byte_q};
  assign dy = {header_q[SIGN_Y_BIT], data_byte_i};

  ps2mt_clamp #(.POSITION_BITS(POSITION_BITS)) u_clamp_x (
    .pos_i      (ptr_x_q),
    .delta_i    (dx),
    .subtract_i (1'b0),
    .res_i      (x_res_q),
    .hi_o       (x_hi),
    .pos_o      (new_x)
  );

  ps2mt_clamp #(.POSITION_BITS(POSITION_BITS)) u_clamp_y (
    .pos_i      (ptr_y_q),
    .delta_i    (dy),
    .subtract_i (1'b1),
    .res_i      (y_res_q),
    .hi_o       (y_hi),
    .pos_o      (new_y)
  );

  always_comb begin
    pos_d    = pos_q;
    header_d = header_q;
    x_byte_d = x_byte_q;
    if (in_accept) begin
      unique case (pos_q)
        POS_X: begin
          x_byte_d = data_byte_i;
          pos_d    = POS_Y;
        end
        POS_Y: begin
          pos_d = POS_HEADER;
        end
        default: begin
          if (data_byte_i[SYNC_BIT]) begin
            header_d = data_byte_i;
            pos_d    = POS_X;
          end else begin
            pos_d = POS_HEADER;
          end
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_accept) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_res_q     <= X_RES_RESET;
      y_res_q     <= Y_RES_RESET;
      pos_q       <= POS_HEADER;
      header_q    <= '0;
      x_byte_q    <= '0;
      ptr_x_q     <= POSITION_BITS'(512);
      ptr_y_q     <= POSITION_BITS'(384);
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_X_RES: x_res_q <= cfg_data_i;
          CFG_Y_RES: y_res_q <= cfg_data_i;
          default:   ;
        endcase
      end
      pos_q       <= pos_d;
      header_q    <= header_d;
      x_byte_q    <= x_byte_d;
      out_valid_q <= out_valid_d;
      if (load) begin
        ptr_x_q <= new_x;
        ptr_y_q <= new_y;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      left_q   <= header_q[BTN_LEFT_BIT];
      right_q  <= header_q[BTN_RIGHT_BIT];
      mid_q    <= header_q[BTN_MID_BIT];
      ovf_x_q  <= header_q[OVF_X_BIT];
      ovf_y_q  <= header_q[OVF_Y_BIT];
      move_x_q <= dx;
      move_y_q <= dy;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign left_button_o     = left_q;
  assign right_button_o    = right_q;
  assign middle_button_o   = mid_q;
  assign x_overflow_flag_o = ovf_x_q;
  assign y_overflow_flag_o = ovf_y_q;
  assign move_x_o          = move_x_q;
  assign move_y_o          = move_y_q;
  assign cursor_x_o        = ptr_x_q;
  assign cursor_y_o        = ptr_y_q;

  `ASSERT_NXT(a_third_byte_loads, clk_i, rst_ni, load, out_valid_o, "third byte lost its result")
  `ASSERT_NXT(a_no_sync_drop, clk_i, rst_ni,
              in_accept && (pos_q == POS_HEADER) && !data_byte_i[SYNC_BIT],
              (pos_q == POS_HEADER) && !$rose(out_valid_o), "unsynced byte started a packet")
  `ASSERT_NXT(a_cursor_in_range, clk_i, rst_ni, load,
              (cursor_x_o <= x_hi) && (cursor_y_o <= y_hi), "cursor outside clamp range")

endmodule

FILE: tb/ps2mt_packet_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ps2mt_packet_checker
// watches the byte, packet and register ports of the mouse tracker, keeps
// its own decoder and cursor state, and compares every packet field by field
// ----------------------------------------------------------------------------
module ps2mt_packet_checker #(
  parameter int unsigned POSITION_BITS = 12
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ps2mt_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ps2mt_pkg::RES_W-1:0]     cfg_data_i,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  logic [ps2mt_pkg::BYTE_W-1:0]    data_byte_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  logic                            left_button_i,
  input  logic                            right_button_i,
  input  logic                            middle_button_i,
  input  logic                            x_overflow_flag_i,
  input  logic                            y_overflow_flag_i,
  input  ps2mt_pkg::delta_t               move_x_i,
  input  ps2mt_pkg::delta_t               move_y_i,
  input  logic [POSITION_BITS-1:0]        cursor_x_i,
  input  logic [POSITION_BITS-1:0]        cursor_y_i,
  output int                              fail_count_o,
  output int                              pending_o,
  output int                              packets_o
);

  typedef struct {
    logic                     left;
    logic                     right;
    logic                     middle;
    logic                     x_ovf;
    logic                     y_ovf;
    ps2mt_pkg::delta_t        dx;
    ps2mt_pkg::delta_t        dy;
    logic [POSITION_BITS-1:0] cx;
    logic [POSITION_BITS-1:0] cy;
  } mouse_packet_t;

  mouse_packet_t                  expected_packets [$];
  logic [1:0]                     byte_pos;
  logic [ps2mt_pkg::BYTE_W-1:0]   header;
  logic [ps2mt_pkg::BYTE_W-1:0]   x_byte;
  logic [ps2mt_pkg::RES_W-1:0]    x_res;
  logic [ps2mt_pkg::RES_W-1:0]    y_res;
  int                             ptr_x;
  int                             ptr_y;

  function automatic int clamp_to_screen(int v, logic [ps2mt_pkg::RES_W-1:0] res);
    int hi;
    hi = (res == 0) ? 0 : int'(res) - 1;
    if (hi > (1 << POSITION_BITS) - 1) hi = (1 << POSITION_BITS) - 1;
    if (v < 0) v = 0;
    if (v > hi) v = hi;
    return v;
  endfunction

  task automatic track_byte(input logic [ps2mt_pkg::BYTE_W-1:0] b);
    mouse_packet_t p;
    int            dx;
    int            dy;
    case (byte_pos)
      ps2mt_pkg::POS_X: begin
        x_byte   = b;
        byte_pos = ps2mt_pkg::POS_Y;
      end
      ps2mt_pkg::POS_Y: begin
        byte_pos = ps2mt_pkg::POS_HEADER;
        dx = header[ps2mt_pkg::SIGN_X_BIT] ? int'(x_byte) - 256 : int'(x_byte);
        dy = header[ps2mt_pkg::SIGN_Y_BIT] ? int'(b) - 256 : int'(b);
        ptr_x = clamp_to_screen(ptr_x + dx, x_res);
        ptr_y = clamp_to_screen(ptr_y - dy, y_res);
        p.left   = header[ps2mt_pkg::BTN_LEFT_BIT];
        p.right  = header[ps2mt_pkg::BTN_RIGHT_BIT];
        p.middle = header[ps2mt_pkg::BTN_MID_BIT];
        p.x_ovf  = header[ps2mt_pkg::OVF_X_BIT];
        p.y_ovf  = header[ps2mt_pkg::OVF_Y_BIT];
        p.dx     = dx[ps2mt_pkg::DELTA_W-1:0];
        p.dy     = dy[ps2mt_pkg::DELTA_W-1:0];
        p.cx     = ptr_x[POSITION_BITS-1:0];
        p.cy     = ptr_y[POSITION_BITS-1:0];
        expected_packets.push_back(p);
      end
      default: begin
        if (b[ps2mt_pkg::SYNC_BIT]) begin
          header   = b;
          byte_pos = ps2mt_pkg::POS_X;
        end else begin
          byte_pos = ps2mt_pkg::POS_HEADER;
        end
      end
    endcase
  endtask

  task automatic compare_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      fail_count_o++;
    end
  endtask

  task automatic check_packet();
    mouse_packet_t want;
    if (expected_packets.size() == 0) begin
      $display("%0t: packet with no request pending, cursor %0d,%0d", $time,
               cursor_x_i, cursor_y_i);
      fail_count_o++;
    end else begin
      want = expected_packets.pop_front();
      packets_o++;
      compare_field("left_button", want.left, left_button_i);
      compare_field("right_button", want.right, right_button_i);
      compare_field("middle_button", want.middle, middle_button_i);
      compare_field("x_overflow_flag", want.x_ovf, x_overflow_flag_i);
      compare_field("y_overflow_flag", want.y_ovf, y_overflow_flag_i);
      compare_field("move_x", want.dx, move_x_i);
      compare_field("move_y", want.dy, move_y_i);
      compare_field("cursor_x", want.cx, cursor_x_i);
      compare_field("cursor_y", want.cy, cursor_y_i);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_packets.delete();
      byte_pos     = ps2mt_pkg::POS_HEADER;
      header       = '0;
      x_byte       = '0;
      x_res        = ps2mt_pkg::X_RES_RESET;
      y_res        = ps2mt_pkg::Y_RES_RESET;
      ptr_x        = 512;
      ptr_y        = 384;
      fail_count_o = 0;
      packets_o    = 0;
    end else begin
      if (out_valid_i && !out_stall_i) check_packet();
      if (in_valid_i && !in_stall_i) track_byte(data_byte_i);
      if (cfg_we_i) begin
        if (cfg_index_i == ps2mt_pkg::CFG_X_RES) x_res = cfg_data_i;
        else if (cfg_index_i == ps2mt_pkg::CFG_Y_RES) y_res = cfg_data_i;
      end
    end
    pending_o = expected_packets.size();
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// drives mouse bytes, register writes and output stalls into the tracker;
// a directed opening is followed by mostly well-formed random packets under
// several screen sizes, with random gaps, a gap-free phase and a long stall
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned POSITION_BITS   = 12;
  localparam int          IDLE_PCT        = 26;
  localparam int          HOLD_CYCLES     = 60;
  localparam int          WATCHDOG_LIMIT  = 5000;
  localparam int          BYTES_PER_PHASE = 89;

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [ps2mt_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [ps2mt_pkg::RES_W-1:0]     cfg_data;
  logic                            in_valid;
  logic                            in_stall;
  logic [ps2mt_pkg::BYTE_W-1:0]    data_byte;
  logic                            out_valid;
  logic                            out_stall;
  logic                            left_button;
  logic                            right_button;
  logic                            middle_button;
  logic                            x_overflow_flag;
  logic                            y_overflow_flag;
  ps2mt_pkg::delta_t               move_x;
  ps2mt_pkg::delta_t               move_y;
  logic [POSITION_BITS-1:0]        cursor_x;
  logic [POSITION_BITS-1:0]        cursor_y;

  int fail_count;
  int pending;
  int packets;
  int sent_bytes;
  int stuck_cycles;
  bit calm;
  bit hold_req;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  ps2_mouse_packet_cursor_tracker_core #(
    .POSITION_BITS(POSITION_BITS)
  ) dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .data_byte_i      (data_byte),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .left_button_o    (left_button),
    .right_button_o   (right_button),
    .middle_button_o  (middle_button),
    .x_overflow_flag_o(x_overflow_flag),
    .y_overflow_flag_o(y_overflow_flag),
    .move_x_o         (move_x),
    .move_y_o         (move_y),
    .cursor_x_o       (cursor_x),
    .cursor_y_o       (cursor_y)
  );

  ps2mt_packet_checker #(
    .POSITION_BITS(POSITION_BITS)
  ) checker_i (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .data_byte_i      (data_byte),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .left_button_i    (left_button),
    .right_button_i   (right_button),
    .middle_button_i  (middle_button),
    .x_overflow_flag_i(x_overflow_flag),
    .y_overflow_flag_i(y_overflow_flag),
    .move_x_i         (move_x),
    .move_y_i         (move_y),
    .cursor_x_i       (cursor_x),
    .cursor_y_i       (cursor_y),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .packets_o        (packets)
  );

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, stuck_cycles);
      $display("Test completed with failures");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // packet receiver, with one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  task automatic send_mouse_byte(input logic [ps2mt_pkg::BYTE_W-1:0] b);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_bytes++;
    @(negedge clk);
  endtask

  task automatic random_traffic(input int n);
    int                           count;
    logic [ps2mt_pkg::BYTE_W-1:0] b;
    count = 0;
    while (count < n) begin
      if ($urandom_range(0, 99) < 85) begin
        b = $urandom_range(0, 255);
        b[ps2mt_pkg::SYNC_BIT] = 1'b1;
        send_mouse_byte(b);
        b = $urandom_range(0, 255);
        send_mouse_byte(b);
        b = $urandom_range(0, 255);
        send_mouse_byte(b);
        count += 3;
      end else begin
        // stray byte: dropped, taken as a header, or taken as data after a stray header
        b = $urandom_range(0, 255);
        send_mouse_byte(b);
        count++;
      end
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic set_resolution(input logic [ps2mt_pkg::CFG_IDX_W-1:0] idx,
                                input logic [ps2mt_pkg::RES_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    logic [ps2mt_pkg::BYTE_W-1:0] opening [$];
    logic [ps2mt_pkg::RES_W-1:0]  xr;
    logic [ps2mt_pkg::RES_W-1:0]  yr;
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = ps2mt_pkg::CFG_X_RES;
    cfg_data   = '0;
    in_valid   = 1'b0;
    data_byte  = '0;
    calm       = 1'b0;
    hold_req   = 1'b0;
    sent_bytes = 0;
    stuck_cycles = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    opening = '{8'h00, 8'hF7,
                8'h08, 8'h00, 8'h00,
                8'hFF, 8'hFF, 8'hFF,
                8'h08, 8'hFF, 8'hFF,
                8'h08, 8'hFF, 8'h00,
                8'h08, 8'hFF, 8'h00,
                8'h38, 8'h00, 8'h00,
                8'h0F, 8'h70, 8'hF7};
    foreach (opening[i]) send_mouse_byte(opening[i]);
    random_traffic(BYTES_PER_PHASE);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin xr = 0; yr = 1; end
        1: begin xr = 8191; yr = 4096; end
        2: begin xr = 640; yr = 480; end
        3: begin xr = 1; yr = 0; end
        4: begin xr = 4096; yr = 8191; end
        default: begin
          xr = $urandom_range(1, 4096);
          yr = $urandom_range(1, 4096);
        end
      endcase
      set_resolution(ps2mt_pkg::CFG_X_RES, xr);
      set_resolution(ps2mt_pkg::CFG_Y_RES, yr);
      calm = (ph == 4);
      if (ph == 2) hold_req = 1'b1;
      random_traffic(BYTES_PER_PHASE);
      drain();
    end
    calm = 1'b0;
    repeat (4) @(negedge clk);

    $display("sent %0d mouse bytes, checked %0d packets", sent_bytes, packets);
    $display("screen sizes covered reset, zero, one, 640x480, 4096, 8191 and random");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
